// File: src/clr_pkg.sv
// Shared types, constants and coefficient tables for the 27-to-10 complex recombination.
// Used by the top level, the multiply-accumulate unit and the checker. No dependencies.
package clr_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int NSAMP            = 27;
    localparam int NMID             = 9;
    localparam int NRES             = 10;
    localparam int COEF_W           = 21;
    localparam int COEF_FRAC        = 18;
    localparam int ACC_W            = 64;
    localparam int IDX_W            = 4;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));

    localparam logic signed [COEF_W-1:0] K1  = 21'sd262144;
    localparam logic signed [COEF_W-1:0] KH  = 21'sd131072;
    localparam logic signed [COEF_W-1:0] KQ  = 21'sd65536;
    localparam logic signed [COEF_W-1:0] KT  = 21'sd196608;
    localparam logic signed [COEF_W-1:0] KR  = 21'sd227023;
    localparam logic signed [COEF_W-1:0] KS  = 21'sd113512;
    localparam logic signed [COEF_W-1:0] K3  = 21'sd786432;
    localparam logic signed [COEF_W-1:0] KQ3 = 21'sd454047;
    localparam logic signed [COEF_W-1:0] D12 = 21'sd21845;
    localparam logic signed [COEF_W-1:0] D6  = 21'sd43691;
    localparam logic signed [COEF_W-1:0] D3  = 21'sd87381;
    localparam logic signed [COEF_W-1:0] KZ  = 21'sd0;

    localparam logic signed [COEF_W-1:0] ST1 [NMID][NSAMP] = '{
        '{K1,K1,K1, KZ,KZ,KZ, KZ,KZ,KZ,  KZ,KZ,KZ, KZ,KZ,KZ, KZ,KZ,KZ,
          KZ,KZ,KZ, KZ,KZ,KZ, KZ,KZ,KZ},
        '{KZ,KH,-KH, K1,-KH,-KH, KZ,-KR,KR,  KZ,KZ,KZ, KZ,KZ,KZ, KZ,KZ,KZ,
          KZ,KZ,KZ, KZ,KZ,KZ, KZ,KZ,KZ},
        '{KZ,KR,KR, KZ,KR,-KR, K1,-KH,-KH,  KZ,KZ,KZ, KZ,KZ,KZ, KZ,KZ,KZ,
          KZ,KZ,KZ, KZ,KZ,KZ, KZ,KZ,KZ},
        '{KZ,KH,-KH, KZ,KZ,KZ, KZ,KZ,KZ,  K1,-KH,-KH, KZ,KZ,KZ, KZ,KZ,KZ,
          KZ,-KR,KR, KZ,KZ,KZ, KZ,KZ,KZ},
        '{KZ,KQ,KQ, KZ,-KQ,KQ, KZ,-KS,-KS,  KZ,-KQ,KQ, K1,KQ,KQ, KZ,KS,-KS,
          KZ,-KS,-KS, KZ,KS,-KS, KZ,KT,KT},
        '{KZ,KS,-KS, KZ,KS,KS, KZ,-KQ,KQ,  KZ,-KS,-KS, KZ,-KS,KS, K1,KQ,KQ,
          KZ,-KT,KT, KZ,-KT,-KT, KZ,KS,-KS},
        '{KZ,KR,KR, KZ,KZ,KZ, KZ,KZ,KZ,  KZ,KR,-KR, KZ,KZ,KZ, KZ,KZ,KZ,
          K1,-KH,-KH, KZ,KZ,KZ, KZ,KZ,KZ},
        '{KZ,KS,-KS, KZ,-KS,-KS, KZ,-KT,KT,  KZ,KS,KS, KZ,-KS,KS, KZ,-KT,-KT,
          KZ,-KQ,KQ, K1,KQ,KQ, KZ,KS,-KS},
        '{KZ,KT,KT, KZ,KT,-KT, KZ,-KS,-KS,  KZ,KT,-KT, KZ,KT,KT, KZ,-KS,KS,
          KZ,-KS,-KS, KZ,-KS,KS, K1,KQ,KQ}
    };

    localparam logic signed [COEF_W-1:0] ST2 [NRES][NMID] = '{
        '{K3,-K3,-KQ3, -K3,K3,KQ3, -KQ3,KQ3,K1},
        '{K3,K3,-KQ3, -K3,-K3,KQ3, -KQ3,-KQ3,K1},
        '{KZ,KZ,KQ3, KZ,KZ,-KQ3, KZ,KZ,-K1},
        '{K3,-K3,-KQ3, K3,-K3,-KQ3, -KQ3,KQ3,K1},
        '{K3,K3,-KQ3, K3,K3,-KQ3, -KQ3,-KQ3,K1},
        '{KZ,KZ,KQ3, KZ,KZ,KQ3, KZ,KZ,-K1},
        '{KZ,KZ,KZ, KZ,KZ,KZ, KQ3,-KQ3,-K1},
        '{KZ,KZ,KZ, KZ,KZ,KZ, KQ3,KQ3,-K1},
        '{KZ,KZ,KZ, KZ,KZ,KZ, KZ,KZ,K1},
        '{K1,KZ,KZ, KZ,KZ,KZ, KZ,KZ,KZ}
    };

    localparam logic signed [COEF_W-1:0] SCL [NRES] = '{D12, D12, D6, D12, D12, D6, D6, D6, D3, K1};

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic clr;   // zero the accumulator
        logic mul;   // launch a partial product
        logic hi;    // use the upper 32-bit half of the operand
    } t_mac_ctl;

    // Round half up and drop the coefficient fraction
    function automatic logic signed [ACC_W-1:0] round_q(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = v + RND_HALF;
        return s >>> COEF_FRAC;
    endfunction

endpackage

// File: src/clr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module clr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 27
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/clr_mac.sv
// Shared multiply-accumulate unit: 21-bit coefficient times one 32-bit half of a
// 64-bit operand per cycle, product registered, then added modulo 2^64. Uses clr_pkg.
module clr_mac (
    input  logic                                  i_clk,
    input  clr_pkg::t_mac_ctl                     i_ctl,
    input  logic signed [clr_pkg::COEF_W-1:0]     i_coef,
    input  logic signed [clr_pkg::ACC_W-1:0]      i_opnd,
    output logic signed [clr_pkg::ACC_W-1:0]      o_acc
);

    localparam int HALF_W = clr_pkg::ACC_W / 2;
    localparam int PROD_W = clr_pkg::COEF_W + HALF_W + 1;

    logic signed [HALF_W:0]               w_chunk;
    logic signed [PROD_W-1:0]             r_prod;
    logic                                 r_prod_vld;
    logic                                 r_prod_hi;
    logic signed [clr_pkg::ACC_W-1:0]     r_acc;
    logic signed [clr_pkg::ACC_W-1:0]     w_addend;

    // Low half is unsigned, high half carries the sign
    assign w_chunk = i_ctl.hi ? $signed({i_opnd[clr_pkg::ACC_W-1], i_opnd[clr_pkg::ACC_W-1:HALF_W]})
                              : $signed({1'b0, i_opnd[HALF_W-1:0]});

    assign w_addend = r_prod_hi ? $signed({r_prod[HALF_W-1:0], {HALF_W{1'b0}}})
                                : clr_pkg::ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod_vld <= i_ctl.mul;
        r_prod_hi  <= i_ctl.hi;
        if (i_ctl.mul) begin
            r_prod <= i_coef * w_chunk;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + w_addend;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: src/complex_linear_recombine_27_to_10.sv
// Top level: sample store, intermediate matrix, sequencer and result register.
// Depends on clr_pkg, clr_ram and clr_mac.
//
//  channel  | direction | handshake                        | payload
//  ---------+-----------+----------------------------------+---------------------------------
//  sample   | in        | i_sample_valid / o_sample_ready  | i_sample_re, i_sample_im
//  result   | out       | o_result_valid / i_result_ready  | index, re, im, last, saturated
//
// Samples 1..26 of a batch are written to the sample store. The 27th starts the batch computation,
// which runs every product through the single shared multiply-accumulate unit, two
// partial products per term: the 486 first-map terms (fetch, low and high half per
// term, then drain and store per entry), then the ten results (per part: the term
// products, drain, round, then the scale product, drain and done).
// Sample input is not ready while the batch is computed, until the last result enters the output register.
// A result waits in the output register; a stall holds the sequencer at the next result.
// Reset (synchronous, active low) clears the sequencer and the output valid only.
module complex_linear_recombine_27_to_10 #(
    parameter int SAMPLE_WIDTH = clr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_sample_valid,
    output logic                           o_sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_im,
    output logic                           o_result_valid,
    input  logic                           i_result_ready,
    output logic [clr_pkg::IDX_W-1:0]      o_result_index,
    output logic signed [SAMPLE_WIDTH+7:0] o_result_re,
    output logic signed [SAMPLE_WIDTH+7:0] o_result_im,
    output logic                           o_last_result,
    output logic                           o_saturated
);

    localparam int OUT_W  = SAMPLE_WIDTH + 8;
    localparam int MID_W  = SAMPLE_WIDTH + 16;
    localparam int ACC_W  = clr_pkg::ACC_W;
    localparam int ADDR_W = $clog2(clr_pkg::NSAMP);

    typedef enum logic [3:0] {
        LOAD, S1_FETCH, S1_LO, S1_HI, S1_DRAIN, S1_STORE,
        S2_LO, S2_HI, S2_DRAIN, S2_ROUND, SC_LO, SC_HI, SC_DRAIN, SC_DONE
    } t_state;

    t_state                              r_state;
    logic [ADDR_W-1:0]                   r_cnt;
    logic [clr_pkg::IDX_W-1:0]           r_m;
    logic [clr_pkg::IDX_W-1:0]           r_t;
    logic                                r_p;
    logic signed [MID_W-1:0]             r_mid [clr_pkg::NMID][2];
    logic signed [ACC_W-1:0]             r_opnd;
    logic signed [OUT_W-1:0]             r_re_hold;
    logic                                r_sat_hold;
    logic                                r_out_valid;
    logic [clr_pkg::IDX_W-1:0]           r_out_index;
    logic signed [OUT_W-1:0]             r_out_re;
    logic signed [OUT_W-1:0]             r_out_im;
    logic                                r_out_last;
    logic                                r_out_sat;

    logic                                w_accept;
    logic                                w_ram_re;
    logic [2*SAMPLE_WIDTH-1:0]           w_ram_rdata;
    logic signed [SAMPLE_WIDTH-1:0]      w_smp;
    clr_pkg::t_mac_ctl                   w_ctl;
    logic signed [clr_pkg::COEF_W-1:0]   w_coef;
    logic signed [ACC_W-1:0]             w_opnd;
    logic signed [ACC_W-1:0]             w_acc;
    logic signed [ACC_W-1:0]             w_rnd;
    logic                                w_fits;
    logic signed [OUT_W-1:0]             w_sat_val;
    logic                                w_out_free;
    logic                                w_out_load;

    assign o_sample_ready = (r_state == LOAD);
    assign w_accept       = i_sample_valid && o_sample_ready;
    assign w_ram_re       = (r_state == S1_FETCH);
    assign w_out_free     = !r_out_valid || i_result_ready;
    assign w_out_load     = (r_state == SC_DONE) && r_p && w_out_free;

    clr_ram #(
        .WIDTH (2 * SAMPLE_WIDTH),
        .DEPTH (clr_pkg::NSAMP)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_cnt),
        .i_wdata ({i_sample_im, i_sample_re}),
        .i_re    (w_ram_re),
        .i_raddr (r_cnt),
        .o_rdata (w_ram_rdata)
    );

    assign w_smp = r_p ? w_ram_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]
                       : w_ram_rdata[SAMPLE_WIDTH-1:0];

    always_comb begin
        w_ctl  = '0;
        w_coef = clr_pkg::ST1[r_m][r_cnt];
        w_opnd = ACC_W'(w_smp);
        case (r_state)
            S1_LO: begin
                w_ctl.mul = 1'b1;
            end
            S1_HI: begin
                w_ctl.mul = 1'b1;
                w_ctl.hi  = 1'b1;
            end
            S2_LO, S2_HI: begin
                w_ctl.mul = 1'b1;
                w_ctl.hi  = (r_state == S2_HI);
                w_coef    = clr_pkg::ST2[r_m][r_t];
                w_opnd    = ACC_W'(r_mid[r_t][r_p]);
            end
            SC_LO, SC_HI: begin
                w_ctl.mul = 1'b1;
                w_ctl.hi  = (r_state == SC_HI);
                w_coef    = clr_pkg::SCL[r_m];
                w_opnd    = r_opnd;
            end
            LOAD: begin
                w_ctl.clr = w_accept;
            end
            S1_STORE, S2_ROUND: begin
                w_ctl.clr = 1'b1;
            end
            SC_DONE: begin
                w_ctl.clr = !r_p || w_out_free;
            end
            default: begin
            end
        endcase
    end

    clr_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_coef (w_coef),
        .i_opnd (w_opnd),
        .o_acc  (w_acc)
    );

    assign w_rnd     = clr_pkg::round_q(w_acc);
    assign w_fits    = (&w_rnd[ACC_W-1:OUT_W-1]) || !(|w_rnd[ACC_W-1:OUT_W-1]);
    assign w_sat_val = w_fits ? w_rnd[OUT_W-1:0]
                              : (w_rnd[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                : {1'b0, {(OUT_W-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= LOAD;
            r_cnt       <= '0;
            r_m         <= '0;
            r_t         <= '0;
            r_p         <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_result_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                LOAD: begin
                    if (w_accept) begin
                        if (r_cnt == ADDR_W'(clr_pkg::NSAMP - 1)) begin
                            r_cnt   <= '0;
                            r_m     <= '0;
                            r_p     <= 1'b0;
                            r_state <= S1_FETCH;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S1_FETCH: r_state <= S1_LO;
                S1_LO:    r_state <= S1_HI;
                S1_HI: begin
                    if (r_cnt == ADDR_W'(clr_pkg::NSAMP - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S1_DRAIN;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S1_FETCH;
                    end
                end
                S1_DRAIN: r_state <= S1_STORE;
                S1_STORE: begin
                    r_mid[r_m][r_p] <= w_rnd[MID_W-1:0];
                    r_p             <= !r_p;
                    if (r_p && r_m == clr_pkg::IDX_W'(clr_pkg::NMID - 1)) begin
                        r_m     <= '0;
                        r_t     <= '0;
                        r_state <= S2_LO;
                    end else begin
                        if (r_p) begin
                            r_m <= r_m + 1'b1;
                        end
                        r_state <= S1_FETCH;
                    end
                end
                S2_LO: r_state <= S2_HI;
                S2_HI: begin
                    if (r_t == clr_pkg::IDX_W'(clr_pkg::NMID - 1)) begin
                        r_t     <= '0;
                        r_state <= S2_DRAIN;
                    end else begin
                        r_t     <= r_t + 1'b1;
                        r_state <= S2_LO;
                    end
                end
                S2_DRAIN: r_state <= S2_ROUND;
                S2_ROUND: begin
                    r_opnd  <= w_rnd;
                    r_state <= SC_LO;
                end
                SC_LO:    r_state <= SC_HI;
                SC_HI:    r_state <= SC_DRAIN;
                SC_DRAIN: r_state <= SC_DONE;
                SC_DONE: begin
                    if (!r_p) begin
                        r_re_hold  <= w_sat_val;
                        r_sat_hold <= !w_fits;
                        r_p        <= 1'b1;
                        r_state    <= S2_LO;
                    end else if (w_out_free) begin
                        // hold here until the output register can take the result
                        r_out_index <= r_m;
                        r_out_re    <= r_re_hold;
                        r_out_im    <= w_sat_val;
                        r_out_last  <= (r_m == clr_pkg::IDX_W'(clr_pkg::NRES - 1));
                        r_out_sat   <= r_sat_hold || !w_fits;
                        r_p         <= 1'b0;
                        if (r_m == clr_pkg::IDX_W'(clr_pkg::NRES - 1)) begin
                            r_m     <= '0;
                            r_state <= LOAD;
                        end else begin
                            r_m     <= r_m + 1'b1;
                            r_state <= S2_LO;
                        end
                    end
                end
                default: r_state <= LOAD;
            endcase
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_result_re    = r_out_re;
    assign o_result_im    = r_out_im;
    assign o_last_result  = r_out_last;
    assign o_saturated    = r_out_sat;

endmodule

// File: src/clr_chk.sv
// Port-level checker for the 27-to-10 recombination block, bound to the top level.
// Depends on clr_pkg and complex_linear_recombine_27_to_10.
module clr_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_sample_ready,
    input logic                      o_result_valid,
    input logic                      i_result_ready,
    input logic [clr_pkg::IDX_W-1:0] o_result_index,
    input logic                      o_last_result
);

    localparam logic [clr_pkg::IDX_W-1:0] LAST_IDX = clr_pkg::IDX_W'(clr_pkg::NRES - 1);

    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=> $stable(o_result_index))
        else $error("result index changed during stall");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_last_result == (o_result_index == LAST_IDX)))
        else $error("last flag does not match index");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result_index <= LAST_IDX))
        else $error("result index out of range");

    a_busy_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_result_index != LAST_IDX) |-> !o_sample_ready)
        else $error("sample request taken while results are pending");

endmodule

bind complex_linear_recombine_27_to_10 clr_chk u_clr_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_sample_ready (o_sample_ready),
    .o_result_valid (o_result_valid),
    .i_result_ready (i_result_ready),
    .o_result_index (o_result_index),
    .o_last_result  (o_last_result)
);
